>>> hdl/hybrid_steering_dead_reckoning_assert.svh
// Assertion macros used by the checker file
`ifndef HYBRID_STEERING_DEAD_RECKONING_ASSERT_SVH
`define HYBRID_STEERING_DEAD_RECKONING_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HSDR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define HSDR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/hsdr_pkg.sv
package hsdr_pkg;

	localparam int TRIG_W = 34;
	localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032875;

	typedef enum logic [1:0] {
		MODE_STRAIGHT = 2'd0,
		MODE_LEFT     = 2'd1,
		MODE_RIGHT    = 2'd2
	} steer_mode_t;

	typedef enum logic [2:0] {
		REG_SPEED_STEP   = 3'd0,
		REG_TURN_STEP    = 3'd1,
		REG_EPS_LOW      = 3'd2,
		REG_EPS_HIGH     = 3'd3,
		REG_TRACK_CENTER = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_MUL_C,
		ST_MUL_S,
		ST_ADD_Y,
		ST_DIST,
		ST_OFF,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		ADD_X,
		ADD_Y,
		ADD_DIST,
		ADD_OFF
	} add_sel_t;

	// arctangent of 2^-i, 2^32 units per turn
	function automatic logic signed [TRIG_W-1:0] atan_turn(input logic [4:0] i);
		logic signed [TRIG_W-1:0] r;
		case (i)
			5'd0:  r = 34'sd536870912;
			5'd1:  r = 34'sd316933406;
			5'd2:  r = 34'sd167458907;
			5'd3:  r = 34'sd85004756;
			5'd4:  r = 34'sd42667331;
			5'd5:  r = 34'sd21354465;
			5'd6:  r = 34'sd10679838;
			5'd7:  r = 34'sd5340245;
			5'd8:  r = 34'sd2670163;
			5'd9:  r = 34'sd1335087;
			5'd10: r = 34'sd667544;
			5'd11: r = 34'sd333772;
			5'd12: r = 34'sd166886;
			5'd13: r = 34'sd83443;
			5'd14: r = 34'sd41722;
			5'd15: r = 34'sd20861;
			5'd16: r = 34'sd10430;
			5'd17: r = 34'sd5215;
			5'd18: r = 34'sd2608;
			5'd19: r = 34'sd1304;
			5'd20: r = 34'sd652;
			5'd21: r = 34'sd326;
			5'd22: r = 34'sd163;
			5'd23: r = 34'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/hsdr_if.sv
interface hsdr_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] disturbance;

	modport source (output valid, output disturbance, input ready);
	modport sink (input valid, input disturbance, output ready);
endinterface

interface hsdr_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0]        heading;
	logic [1:0]         steer_mode;
	logic signed [31:0] offset;

	modport source (output valid, output pos_x, output pos_y, output heading,
		output steer_mode, output offset, input ready);
	modport sink (input valid, input pos_x, input pos_y, input heading,
		input steer_mode, input offset, output ready);
endinterface

>>> hdl/hsdr_cordic.sv
module hsdr_cordic #(
	parameter int STEPS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [31:0]                          angle,
	output logic                                 done,
	output logic signed [hsdr_pkg::TRIG_W-1:0]   cos_v,
	output logic signed [hsdr_pkg::TRIG_W-1:0]   sin_v
);

	localparam int W  = hsdr_pkg::TRIG_W;
	localparam int CW = $clog2(STEPS);
	localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

	logic signed [W-1:0] x_q, y_q, z_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q, flip_q, done_q;

	logic                flip_in;
	logic [31:0]         a_in;
	logic signed [W-1:0] xs, ys, at, x_n, y_n, z_n;

	always_comb begin
		flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
		a_in    = flip_in ? (angle + 32'h8000_0000) : angle;
		xs      = x_q >>> cnt_q;
		ys      = y_q >>> cnt_q;
		at      = hsdr_pkg::atan_turn(5'(cnt_q));
		if (!z_q[W-1]) begin
			x_n = x_q - ys;
			y_n = y_q + xs;
			z_n = z_q - at;
		end else begin
			x_n = x_q + ys;
			y_n = y_q - xs;
			z_n = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= hsdr_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {{(W-32){a_in[31]}}, a_in};
			flip_q <= flip_in;
		end else if (busy_q) begin
			x_q <= x_n;
			y_q <= y_n;
			z_q <= z_n;
		end
	end

	assign done  = done_q;
	assign cos_v = flip_q ? -x_q : x_q;
	assign sin_v = flip_q ? -y_q : y_q;

endmodule

>>> hdl/hybrid_steering_dead_reckoning.sv
// Bang-bang steering with hysteresis and unicycle dead reckoning.
// sample: one word per control tick, carrying the lateral disturbance (Q16.16).
// result: one word per tick with pose x, y, heading, next steering mode and the
//   offset from the track centre.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle; write only
//   while no tick is in flight.
// An accepted tick runs an iterative CORDIC (one rotation per cycle, CORDIC_STEPS
//   rotations) for cos/sin of the heading, then two passes through one shared
//   multiplier and four passes through one shared saturating adder.
// sample.ready is low while a tick is being worked, so a new tick is taken only
//   after the last one has been handed to the result register.
// The result register lets the next tick start while the last word waits; if the
//   receiver still stalls at the end of the next tick, the block holds there.
// Reset: pose, heading and mode clear to zero (straight), registers load their
//   defaults, result.valid drops.
module hybrid_steering_dead_reckoning #(
	parameter int CORDIC_STEPS = 16,
	parameter int ANGLE_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	hsdr_in_if.sink     sample,
	hsdr_out_if.source  result,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int W = hsdr_pkg::TRIG_W;

	logic [19:0]        speed_q;
	logic [13:0]        turn_q;
	logic [30:0]        eps_low_q;
	logic [30:0]        eps_high_q;
	logic signed [31:0] center_q;

	logic signed [31:0]     x_q, y_q, dist_q, off_q;
	logic [ANGLE_BITS-1:0]  angle_q;
	hsdr_pkg::steer_mode_t  mode_q, mode_n;

	hsdr_pkg::seq_state_t state_q, state_n;
	hsdr_pkg::add_sel_t   add_sel;
	logic                 accept, load_out, mul_sin;

	logic                out_valid_q;
	logic signed [31:0]  out_x_q, out_y_q, out_off_q;
	logic [15:0]         out_head_q;
	hsdr_pkg::steer_mode_t out_mode_q;

	logic                cordic_done;
	logic signed [W-1:0] cos_v, sin_v;
	logic [31:0]         angle32;

	logic signed [20:0]  mul_a;
	logic signed [W-1:0] mul_b;
	logic signed [54:0]  mul_p, prod_q;
	logic signed [24:0]  disp;

	logic signed [33:0]  add_a, add_b, sum;
	logic signed [31:0]  sum_sat;

	logic [31:0]           ts32;
	logic [ANGLE_BITS-1:0] tstep;
	logic signed [32:0]    off_w, mag;

	assign accept  = sample.valid && sample.ready;
	assign angle32 = {angle_q, {(32-ANGLE_BITS){1'b0}}};

	hsdr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.angle  (angle32),
		.done   (cordic_done),
		.cos_v  (cos_v),
		.sin_v  (sin_v)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q    <= 20'd65536;
			turn_q     <= 14'd410;
			eps_low_q  <= 31'd32768;
			eps_high_q <= 31'd65536;
			center_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hsdr_pkg::REG_SPEED_STEP:   speed_q    <= cfg_data[19:0];
				hsdr_pkg::REG_TURN_STEP:    turn_q     <= cfg_data[13:0];
				hsdr_pkg::REG_EPS_LOW:      eps_low_q  <= cfg_data[30:0];
				hsdr_pkg::REG_EPS_HIGH:     eps_high_q <= cfg_data[30:0];
				hsdr_pkg::REG_TRACK_CENTER: center_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			hsdr_pkg::ST_IDLE:  if (accept) state_n = hsdr_pkg::ST_ROT;
			hsdr_pkg::ST_ROT:   if (cordic_done) state_n = hsdr_pkg::ST_MUL_C;
			hsdr_pkg::ST_MUL_C: state_n = hsdr_pkg::ST_MUL_S;
			hsdr_pkg::ST_MUL_S: state_n = hsdr_pkg::ST_ADD_Y;
			hsdr_pkg::ST_ADD_Y: state_n = hsdr_pkg::ST_DIST;
			hsdr_pkg::ST_DIST:  state_n = hsdr_pkg::ST_OFF;
			hsdr_pkg::ST_OFF:   state_n = hsdr_pkg::ST_DONE;
			hsdr_pkg::ST_DONE:  if (!out_valid_q || result.ready) state_n = hsdr_pkg::ST_IDLE;
			default:            state_n = hsdr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = 1'b0;
		mul_sin      = 1'b0;
		load_out     = 1'b0;
		add_sel      = hsdr_pkg::ADD_X;
		unique case (state_q)
			hsdr_pkg::ST_IDLE:  sample.ready = 1'b1;
			hsdr_pkg::ST_MUL_S: begin
				mul_sin = 1'b1;
				add_sel = hsdr_pkg::ADD_X;
			end
			hsdr_pkg::ST_ADD_Y: add_sel = hsdr_pkg::ADD_Y;
			hsdr_pkg::ST_DIST:  add_sel = hsdr_pkg::ADD_DIST;
			hsdr_pkg::ST_OFF:   add_sel = hsdr_pkg::ADD_OFF;
			hsdr_pkg::ST_DONE:  load_out = !out_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hsdr_pkg::ST_IDLE;
		else         state_q <= state_n;
	end

	// speed times trig, rounded half up on the way out
	assign mul_a = $signed({1'b0, speed_q});
	assign mul_b = mul_sin ? sin_v : cos_v;
	assign mul_p = mul_a * mul_b;
	assign disp  = $signed(prod_q[54:30]) + $signed({24'd0, prod_q[29]});

	always_comb begin
		add_a = {{2{y_q[31]}}, y_q};
		add_b = {{9{disp[24]}}, disp};
		case (add_sel)
			hsdr_pkg::ADD_X: begin
				add_a = {{2{x_q[31]}}, x_q};
				add_b = {{9{disp[24]}}, disp};
			end
			hsdr_pkg::ADD_Y:    add_b = {{9{disp[24]}}, disp};
			hsdr_pkg::ADD_DIST: add_b = {{2{dist_q[31]}}, dist_q};
			hsdr_pkg::ADD_OFF:  add_b = -{{2{center_q[31]}}, center_q};
			default: ;
		endcase
		sum = add_a + add_b;
		if (sum > 34'sd2147483647)       sum_sat = 32'sh7FFF_FFFF;
		else if (sum < -34'sd2147483648) sum_sat = 32'sh8000_0000;
		else                             sum_sat = sum[31:0];
	end

	always_comb begin
		ts32  = {2'b00, turn_q, 16'h0000} >> (32 - ANGLE_BITS);
		tstep = ts32[ANGLE_BITS-1:0];
		off_w = {off_q[31], off_q};
		mag   = off_q[31] ? -off_w : off_w;
		mode_n = mode_q;
		if (off_w < -$signed({2'b00, eps_high_q}))
			mode_n = hsdr_pkg::MODE_LEFT;
		else if (off_w > $signed({2'b00, eps_high_q}))
			mode_n = hsdr_pkg::MODE_RIGHT;
		else if (mag < $signed({2'b00, eps_low_q}))
			mode_n = hsdr_pkg::MODE_STRAIGHT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			angle_q <= '0;
			mode_q  <= hsdr_pkg::MODE_STRAIGHT;
		end else begin
			case (state_q)
				hsdr_pkg::ST_MUL_S: x_q <= sum_sat;
				hsdr_pkg::ST_ADD_Y: begin
					y_q <= sum_sat;
					case (mode_q)
						hsdr_pkg::MODE_LEFT:  angle_q <= angle_q + tstep;
						hsdr_pkg::MODE_RIGHT: angle_q <= angle_q - tstep;
						default: ;
					endcase
				end
				hsdr_pkg::ST_DIST: y_q <= sum_sat;
				hsdr_pkg::ST_DONE: if (load_out) mode_q <= mode_n;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) dist_q <= sample.disturbance;
		if (state_q == hsdr_pkg::ST_MUL_C || state_q == hsdr_pkg::ST_MUL_S)
			prod_q <= mul_p;
		if (state_q == hsdr_pkg::ST_OFF) off_q <= sum_sat;
		if (load_out) begin
			out_x_q    <= x_q;
			out_y_q    <= y_q;
			out_head_q <= angle32[31:16];
			out_mode_q <= mode_n;
			out_off_q  <= off_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_valid_q <= 1'b0;
		else if (load_out)     out_valid_q <= 1'b1;
		else if (result.ready) out_valid_q <= 1'b0;
	end

	assign result.valid      = out_valid_q;
	assign result.pos_x      = out_x_q;
	assign result.pos_y      = out_y_q;
	assign result.heading    = out_head_q;
	assign result.steer_mode = out_mode_q;
	assign result.offset     = out_off_q;

endmodule

>>> hdl/hsdr_checker.sv
`include "hybrid_steering_dead_reckoning_assert.svh"

module hsdr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_x,
	input logic [31:0] out_y,
	input logic [15:0] out_head,
	input logic [1:0]  out_mode,
	input logic [31:0] out_off
);

	`HSDR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_head) && $stable(out_mode) && $stable(out_off), "stalled result word changed")
	`HSDR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after a tick was taken")
	`HSDR_ASSERT_NOW(a_result_ends_tick, $rose(out_valid), in_ready && $past(!in_ready), "result word without a finished tick")

endmodule

bind hybrid_steering_dead_reckoning hsdr_checker u_hsdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_x     (result.pos_x),
	.out_y     (result.pos_y),
	.out_head  (result.heading),
	.out_mode  (result.steer_mode),
	.out_off   (result.offset)
);
